// ===== design/tnrn_pkg.sv =====
// ----------------------------------------------------------------------------
// tnrn_pkg
// Shared constants, reply descriptor type and terminal name table for the
// telnet receive negotiator.
// ----------------------------------------------------------------------------
package tnrn_pkg;

    // Telnet command and option bytes.
    localparam logic [7:0] B_IAC     = 8'd255;
    localparam logic [7:0] B_DONT    = 8'd254;
    localparam logic [7:0] B_DO      = 8'd253;
    localparam logic [7:0] B_WONT    = 8'd252;
    localparam logic [7:0] B_WILL    = 8'd251;
    localparam logic [7:0] B_SB      = 8'd250;
    localparam logic [7:0] B_AO      = 8'd245;
    localparam logic [7:0] B_DM      = 8'd242;
    localparam logic [7:0] B_SE      = 8'd240;
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] SUB_SEND  = 8'd1;
    localparam logic [7:0] SUB_IS    = 8'd0;
    localparam logic [7:0] FORM_FEED = 8'h0c;
    localparam logic [7:0] CHAR_MASK = 8'h7f;

    // Input function codes.
    localparam logic [1:0] FUNC_RX     = 2'd0;
    localparam logic [1:0] FUNC_LOCAL  = 2'd1;
    localparam logic [1:0] FUNC_REMOTE = 2'd2;

    // Output destinations.
    localparam logic DEST_TERM = 1'b0;
    localparam logic DEST_NET  = 1'b1;

    // Reply kinds carried from the front to the back.
    localparam logic [1:0] KIND_TERM   = 2'd0;   // one byte to the terminal
    localparam logic [1:0] KIND_AO     = 2'd1;   // IAC DM with urgent mark
    localparam logic [1:0] KIND_NET3   = 2'd2;   // IAC cmd opt
    localparam logic [1:0] KIND_SUBNEG = 2'd3;   // terminal type answer

    localparam int TNRN_STORED_LEN  = 10;
    localparam int TNRN_NAME_LEN    = 10;
    localparam int TNRN_FIFO_DEPTH  = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       echo;
    } t_desc;

    // Stored terminal name, one character per index.
    function automatic logic [7:0] term_name(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h5a;
            4'd1:    ch = 8'h45;
            4'd2:    ch = 8'h4e;
            4'd3:    ch = 8'h49;
            4'd4:    ch = 8'h54;
            4'd5:    ch = 8'h48;
            4'd6:    ch = 8'h2d;
            4'd7:    ch = 8'h48;
            4'd8:    ch = 8'h31;
            4'd9:    ch = 8'h39;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/telnet_receive_negotiator_unit.sv =====
// ----------------------------------------------------------------------------
// telnet_receive_negotiator_unit
// Telnet receive parser with echo, SGA and terminal type negotiation.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------------
//   input   | i_valid / o_ready    | func, rx_byte, urgent_mode,
//           |                      | last_in_segment
//   output  | o_valid / i_ready    | dest, out_byte, push_res, urgent_mark,
//           |                      | echo_remote, last
//
// The parser takes one input beat per cycle while the reply queue has room.
// Each reply leaves at one beat per cycle while the receiver is ready: one
// beat for terminal data, two or three for negotiation, up to sixteen for
// the terminal type answer, so the output sequencer sets the sustained rate when replies are long.
// Synchronous active-low reset clears the parser, echo state, queue and
// output stage. Either side may stall without stopping the other until the
// queue fills.
// ----------------------------------------------------------------------------
module telnet_receive_negotiator_unit
    import tnrn_pkg::*;
#(
    parameter int NAME_LEN   = TNRN_NAME_LEN,
    parameter int FIFO_DEPTH = TNRN_FIFO_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_rx_byte,
    input  logic       i_urgent_mode,
    input  logic       i_last_in_segment,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_dest,
    output logic [7:0] o_out_byte,
    output logic       o_push_res,
    output logic       o_urgent_mark,
    output logic       o_echo_remote,
    output logic       o_last
);

    t_desc push_desc;
    t_desc head_desc;
    logic  push;
    logic  pop;
    logic  empty;
    logic  full;
    logic  seg_end_seen;

    // The segment end mark has no bearing on parsing.
    assign seg_end_seen = i_last_in_segment;

    tnrn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_rx_byte     (i_rx_byte),
        .i_urgent_mode (i_urgent_mode),
        .i_full        (full),
        .o_push        (push),
        .o_desc        (push_desc)
    );

    tnrn_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_head  (head_desc),
        .o_empty (empty),
        .o_full  (full)
    );

    tnrn_back #(
        .NAME_LEN (NAME_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head_desc),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_dest        (o_dest),
        .o_out_byte    (o_out_byte),
        .o_push_res    (o_push_res),
        .o_urgent_mark (o_urgent_mark),
        .o_echo_remote (o_echo_remote),
        .o_last        (o_last)
    );

    a_seg_mark_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> (seg_end_seen == 1'b0 || seg_end_seen == 1'b1))
        else $error("segment end mark undriven on an accepted beat");

    a_ready_tracks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == !full)
        else $error("input ready disagrees with queue state");

    a_term_echo_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> (o_valid && $stable(o_echo_remote)))
        else $error("reply sequence broken or echo mode changed within it");

endmodule

// ===== design/tnrn_front.sv =====
// ----------------------------------------------------------------------------
// tnrn_front
// Parses one input beat per cycle while the reply queue has room, tracks the parser
// and echo state and turns each beat into at most one reply descriptor for the back end.
// ----------------------------------------------------------------------------
module tnrn_front
    import tnrn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_rx_byte,
    input  logic       i_urgent_mode,
    input  logic       i_full,
    output logic       o_push,
    output t_desc      o_desc
);

    localparam logic [3:0] PS_NORMAL  = 4'd0;
    localparam logic [3:0] PS_IAC     = 4'd1;
    localparam logic [3:0] PS_WILL    = 4'd2;
    localparam logic [3:0] PS_WONT    = 4'd3;
    localparam logic [3:0] PS_DO      = 4'd4;
    localparam logic [3:0] PS_DONT    = 4'd5;
    localparam logic [3:0] PS_SB      = 4'd6;
    localparam logic [3:0] PS_SB_TT   = 4'd7;
    localparam logic [3:0] PS_SB_SEND = 4'd8;

    localparam logic [1:0] PEND_NONE   = 2'd0;
    localparam logic [1:0] PEND_LOCAL  = 2'd1;
    localparam logic [1:0] PEND_REMOTE = 2'd2;

    logic [3:0] r_state, n_state;
    logic       r_echo, n_echo;
    logic [1:0] r_pend, n_pend;
    logic       reply;
    logic [1:0] kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_state = r_state;
        n_echo  = r_echo;
        n_pend  = r_pend;
        reply   = 1'b0;
        kind    = KIND_TERM;
        b0      = i_rx_byte;
        b1      = i_rx_byte;
        case (i_func)
            FUNC_RX: begin
                case (r_state)
                    PS_NORMAL: begin
                        if (i_rx_byte == B_IAC) begin
                            n_state = PS_IAC;
                        end else if (!i_urgent_mode && i_rx_byte != FORM_FEED) begin
                            reply = 1'b1;
                            b0    = i_rx_byte & CHAR_MASK;
                        end
                    end
                    PS_IAC: begin
                        n_state = PS_NORMAL;
                        case (i_rx_byte)
                            B_IAC: begin
                                reply = !i_urgent_mode;
                                b0    = B_IAC;
                            end
                            B_AO: begin
                                reply = 1'b1;
                                kind  = KIND_AO;
                            end
                            B_WILL:  n_state = PS_WILL;
                            B_WONT:  n_state = PS_WONT;
                            B_DO:    n_state = PS_DO;
                            B_DONT:  n_state = PS_DONT;
                            B_SB:    n_state = PS_SB;
                            B_SE: begin
                                reply = 1'b1;
                                kind  = KIND_SUBNEG;
                            end
                            default: ;
                        endcase
                    end
                    PS_WILL: begin
                        n_state = PS_NORMAL;
                        kind    = KIND_NET3;
                        if (i_rx_byte == OPT_ECHO) begin
                            // A reply to our own request needs no answer.
                            if (r_pend == PEND_LOCAL) begin
                                n_echo = 1'b1;
                            end else if (r_pend != PEND_REMOTE && !r_echo) begin
                                reply  = 1'b1;
                                b0     = B_DO;
                                n_echo = 1'b1;
                            end
                            n_pend = PEND_NONE;
                        end else if (i_rx_byte == OPT_SGA) begin
                            reply = 1'b1;
                            b0    = B_DO;
                        end else begin
                            reply = 1'b1;
                            b0    = B_DONT;
                        end
                    end
                    PS_WONT: begin
                        n_state = PS_NORMAL;
                        kind    = KIND_NET3;
                        if (i_rx_byte == OPT_ECHO) begin
                            if (r_pend == PEND_REMOTE) begin
                                n_echo = 1'b0;
                            end else if (r_pend != PEND_LOCAL && r_echo) begin
                                reply  = 1'b1;
                                b0     = B_DONT;
                                n_echo = 1'b0;
                            end
                            n_pend = PEND_NONE;
                        end
                    end
                    PS_DO: begin
                        n_state = PS_NORMAL;
                        reply   = 1'b1;
                        kind    = KIND_NET3;
                        b0      = (i_rx_byte == OPT_TTYPE) ? B_WILL : B_WONT;
                    end
                    PS_DONT: begin
                        n_state = PS_NORMAL;
                    end
                    PS_SB: begin
                        n_state = (i_rx_byte == OPT_TTYPE) ? PS_SB_TT : PS_NORMAL;
                    end
                    PS_SB_TT: begin
                        n_state = (i_rx_byte == SUB_SEND) ? PS_SB_SEND : PS_NORMAL;
                    end
                    PS_SB_SEND: begin
                        n_state = (i_rx_byte == B_IAC) ? PS_IAC : PS_NORMAL;
                    end
                    default: begin
                        n_state = PS_NORMAL;
                    end
                endcase
            end
            FUNC_LOCAL: begin
                if (r_echo) begin
                    reply  = 1'b1;
                    kind   = KIND_NET3;
                    b0     = B_DONT;
                    b1     = OPT_ECHO;
                    n_echo = 1'b0;
                    n_pend = PEND_LOCAL;
                end
            end
            FUNC_REMOTE: begin
                if (!r_echo) begin
                    reply  = 1'b1;
                    kind   = KIND_NET3;
                    b0     = B_DO;
                    b1     = OPT_ECHO;
                    n_echo = 1'b1;
                    n_pend = PEND_REMOTE;
                end
            end
            default: ;
        endcase
    end

    assign o_push      = accept && reply;
    assign o_desc.kind = kind;
    assign o_desc.b0   = b0;
    assign o_desc.b1   = b1;
    assign o_desc.echo = n_echo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_NORMAL;
            r_echo  <= 1'b0;
            r_pend  <= PEND_NONE;
        end else if (accept) begin
            r_state <= n_state;
            r_echo  <= n_echo;
            r_pend  <= n_pend;
        end
    end

    // The echo mode only moves together with a cleared or newly set request.
    a_echo_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_REMOTE && !r_echo) |=> (r_echo && r_pend == PEND_REMOTE))
        else $error("remote echo request not recorded");

    a_pend_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("illegal pending echo request");

    a_sb_from_iac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == PS_SB && $past(r_state) != PS_SB) |-> $past(r_state) == PS_IAC)
        else $error("subnegotiation entered without IAC");

endmodule

// ===== design/tnrn_fifo.sv =====
// ----------------------------------------------------------------------------
// tnrn_fifo
// Short descriptor queue between the parser and the reply sequencer.
// ----------------------------------------------------------------------------
module tnrn_fifo
    import tnrn_pkg::*;
#(
    parameter int DEPTH = TNRN_FIFO_DEPTH
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_head,
    output logic  o_empty,
    output logic  o_full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_desc           r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CntFull);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntFull)
        else $error("descriptor queue count out of range");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty descriptor queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full descriptor queue");

endmodule

// ===== design/tnrn_back.sv =====
// ----------------------------------------------------------------------------
// tnrn_back
// Expands the descriptor at the queue head into output beats, one per
// cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module tnrn_back
    import tnrn_pkg::*;
#(
    parameter int NAME_LEN = TNRN_NAME_LEN
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_desc      i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_dest,
    output logic [7:0] o_out_byte,
    output logic       o_push_res,
    output logic       o_urgent_mark,
    output logic       o_echo_remote,
    output logic       o_last
);

    localparam int NameCnt = (NAME_LEN < TNRN_STORED_LEN) ? NAME_LEN : TNRN_STORED_LEN;
    localparam int SeLen   = NameCnt + 6;
    localparam int IdxW    = $clog2(SeLen);
    localparam logic [IdxW-1:0] IdxTail = IdxW'(NameCnt + 4);
    localparam logic [IdxW-1:0] IdxEnd  = IdxW'(NameCnt + 5);

    logic [IdxW-1:0] r_idx;
    logic [IdxW-1:0] name_idx;
    logic            load;
    logic            step;
    logic            g_dest;
    logic [7:0]      g_byte;
    logic            g_push;
    logic            g_urg;
    logic            g_last;

    logic            r_valid;
    logic            r_dest;
    logic [7:0]      r_byte;
    logic            r_push;
    logic            r_urg;
    logic            r_echo;
    logic            r_last;

    assign name_idx = r_idx - IdxW'(4);

    always_comb begin
        g_dest = DEST_NET;
        g_byte = B_IAC;
        g_push = 1'b0;
        g_urg  = 1'b0;
        g_last = 1'b0;
        case (i_head.kind)
            KIND_AO: begin
                if (r_idx != '0) begin
                    g_byte = B_DM;
                    g_urg  = 1'b1;
                    g_last = 1'b1;
                end
            end
            KIND_NET3: begin
                if (r_idx == IdxW'(1)) begin
                    g_byte = i_head.b0;
                end else if (r_idx != '0) begin
                    g_byte = i_head.b1;
                    g_push = 1'b1;
                    g_last = 1'b1;
                end
            end
            KIND_SUBNEG: begin
                if (r_idx == IdxW'(1)) begin
                    g_byte = B_SB;
                end else if (r_idx == IdxW'(2)) begin
                    g_byte = OPT_TTYPE;
                end else if (r_idx == IdxW'(3)) begin
                    g_byte = SUB_IS;
                end else if (r_idx == '0 || r_idx == IdxTail) begin
                    g_byte = B_IAC;
                end else if (r_idx < IdxTail) begin
                    g_byte = term_name(4'(name_idx));
                end else begin
                    g_byte = B_SE;
                    g_push = 1'b1;
                    g_last = 1'b1;
                end
            end
            default: begin
                g_dest = DEST_TERM;
                g_byte = i_head.b0;
                g_last = 1'b1;
            end
        endcase
    end

    // A new beat enters the output register whenever it is empty or drained and the queue holds a descriptor.
    assign load  = !r_valid || i_ready;
    assign step  = load && !i_empty;
    assign o_pop = step && g_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            if (step) begin
                r_idx <= g_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_dest <= g_dest;
            r_byte <= g_byte;
            r_push <= g_push;
            r_urg  <= g_urg;
            r_echo <= i_head.echo;
            r_last <= g_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_dest        = r_dest;
    assign o_out_byte    = r_byte;
    assign o_push_res    = r_push;
    assign o_urgent_mark = r_urg;
    assign o_echo_remote = r_echo;
    assign o_last        = r_last;

    a_idx_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> !i_empty)
        else $error("reply sequence in progress without a descriptor");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IdxEnd)
        else $error("reply index beyond the longest sequence");

    a_urgent_is_dm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_urg) |-> (r_dest == DEST_NET && r_byte == B_DM && r_last))
        else $error("urgent mark on a beat other than the final DM");

    a_push_net: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_push) |-> (r_dest == DEST_NET && r_last))
        else $error("push on a terminal or non-final beat");

endmodule
